// ----- sv/ptq_pkg.sv -----
// ============================================================================
// ptq_pkg - shared types for the priority task queue
// Operation codes, controller states and the command / status bundles that
// pass between the sequencer and the datapath.
// ============================================================================
package ptq_pkg;

  localparam int TAG_IN_W = 8;
  localparam int PRIO_W   = 8;
  localparam int TIME_W   = 32;
  localparam int OP_W     = 2;

  typedef enum logic [OP_W-1:0] {
    OP_INSERT = 2'd0,
    OP_POP    = 2'd1,
    OP_QUERY  = 2'd2,
    OP_NOP    = 2'd3
  } op_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DECIDE,
    ST_SCAN,
    ST_SHIFT,
    ST_SWEEP,
    ST_DRAIN1,
    ST_DRAIN2,
    ST_WR_NEW,
    ST_FINISH
  } state_t;

  typedef enum logic [2:0] {
    IDX_HOLD,
    IDX_ZERO,
    IDX_ONE,
    IDX_LAST,
    IDX_INC,
    IDX_DEC
  } idx_op_t;

  typedef enum logic [1:0] {
    POS_HOLD,
    POS_ZERO,
    POS_LEN,
    POS_SCAN
  } pos_op_t;

  typedef enum logic [1:0] {
    RK_SCAN,
    RK_SHIFT,
    RK_POP,
    RK_QRY
  } rd_kind_t;

  typedef struct packed {
    logic     capture;
    idx_op_t  idx_op;
    logic     rd;
    rd_kind_t rd_kind;
    pos_op_t  pos_op;
    logic     wr_new;
    logic     finish;
  } cmd_t;

  typedef struct packed {
    op_t  op;
    logic len_zero;
    logic full;
    logic urgent_hit;
    logic len_one;
    logic scan_hit;
    logic scan_tail;
    logic idx_at_pos;
    logic idx_at_last;
    logic out_free;
  } sts_t;

endpackage

// ----- sv/ptq_ram.sv -----
// ============================================================================
// ptq_ram - generic single-write, single-read RAM
// One write port, one read port with registered read data.
// ============================================================================
module ptq_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

// ----- sv/ptq_dp.sv -----
// ============================================================================
// ptq_dp - priority task queue datapath
// Entry RAM, length and index counters, read pipeline, slack compare and
// result register.
// ============================================================================
module ptq_dp #(
  parameter int QUEUE_DEPTH = 16,
  parameter int TAG_BITS    = 8
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  ptq_pkg::cmd_t                       cmd,
  output ptq_pkg::sts_t                       sts,
  input  logic                                cfg_valid,
  input  logic [ptq_pkg::PRIO_W-1:0]          cfg_data,
  input  logic [ptq_pkg::OP_W-1:0]            in_operation,
  input  logic [ptq_pkg::TAG_IN_W-1:0]        in_task_tag,
  input  logic [ptq_pkg::PRIO_W-1:0]          in_task_priority,
  input  logic [ptq_pkg::TIME_W-1:0]          in_task_deadline,
  input  logic [ptq_pkg::TIME_W-1:0]          in_current_time,
  input  logic                                out_ready,
  output logic                                out_valid,
  output logic [ptq_pkg::TAG_IN_W-1:0]        out_result_tag,
  output logic                                out_result_valid,
  output logic                                out_insert_dropped,
  output logic [$clog2(QUEUE_DEPTH+1)-1:0]    out_entry_count
);

  localparam int AW     = $clog2(QUEUE_DEPTH);
  localparam int CNT_W  = $clog2(QUEUE_DEPTH + 1);
  localparam int TW     = ptq_pkg::TIME_W;
  localparam int PW     = ptq_pkg::PRIO_W;
  localparam int WORD_W = TAG_BITS + PW + 1 + TW;

  // configuration and queue length
  logic [PW-1:0]    urgent_r;
  logic [CNT_W-1:0] len_r, len_nxt;
  logic [CNT_W-1:0] idx_r, idx_nxt;
  logic [CNT_W-1:0] pos_r, pos_nxt;

  // captured item
  ptq_pkg::op_t     op_r;
  logic [TAG_BITS-1:0] tag_r;
  logic [PW-1:0]    prio_r;
  logic             hasdl_r;
  logic [TW-1:0]    diff_r;
  logic [TW-1:0]    now_r;

  // read pipeline
  logic                  rd_vld_r;
  ptq_pkg::rd_kind_t     rd_kind_r;
  logic [CNT_W-1:0]      rd_idx_r;
  logic [WORD_W-1:0]     rdata;
  logic [TAG_BITS-1:0]   rd_tag;
  logic [PW-1:0]         rd_prio;
  logic                  rd_hasdl;
  logic [TW-1:0]         rd_diff;

  // slack stage and running best
  logic                sv_r;
  logic [TW-1:0]       slack_r;
  logic [TAG_BITS-1:0] stag_r;
  logic                found_r;
  logic [TW-1:0]       best_r;
  logic [TAG_BITS-1:0] rtag_r;

  // result register
  logic                          out_valid_r;
  logic [ptq_pkg::TAG_IN_W-1:0]  out_tag_r;
  logic                          out_rvalid_r;
  logic                          out_drop_r;
  logic [CNT_W-1:0]              out_cnt_r;

  // write port
  logic              we;
  logic [AW-1:0]     waddr;
  logic [WORD_W-1:0] wdata;
  logic [CNT_W-1:0]  rd_idx_up, rd_idx_dn, len_m1;

  logic prio_gt, last_data, full, len_zero;
  logic pop_ok, qry_ok, ins_ok, res_valid, out_free;

  assign rd_tag   = rdata[WORD_W-1 -: TAG_BITS];
  assign rd_prio  = rdata[TW+1 +: PW];
  assign rd_hasdl = rdata[TW];
  assign rd_diff  = rdata[TW-1:0];

  assign len_m1    = len_r - CNT_W'(1);
  assign rd_idx_up = rd_idx_r + CNT_W'(1);
  assign rd_idx_dn = rd_idx_r - CNT_W'(1);
  assign prio_gt   = rd_prio > prio_r;
  assign last_data = rd_idx_r == len_m1;
  assign full      = len_r == CNT_W'(QUEUE_DEPTH);
  assign len_zero  = len_r == '0;
  assign out_free  = !out_valid_r || out_ready;

  always_comb begin
    sts.op          = op_r;
    sts.len_zero    = len_zero;
    sts.full        = full;
    sts.urgent_hit  = prio_r == urgent_r;
    sts.len_one     = len_r == CNT_W'(1);
    sts.scan_hit    = rd_vld_r && (rd_kind_r == ptq_pkg::RK_SCAN) && (prio_gt || last_data);
    sts.scan_tail   = !prio_gt;
    sts.idx_at_pos  = idx_r == pos_r;
    sts.idx_at_last = idx_r == len_m1;
    sts.out_free    = out_free;
  end

  // write port: new entry, or move a read entry one place up or down
  always_comb begin
    we    = 1'b0;
    waddr = pos_r[AW-1:0];
    wdata = rdata;
    if (cmd.wr_new) begin
      we    = 1'b1;
      wdata = {tag_r, prio_r, hasdl_r, diff_r};
    end else if (rd_vld_r && rd_kind_r == ptq_pkg::RK_SHIFT) begin
      we    = 1'b1;
      waddr = rd_idx_up[AW-1:0];
    end else if (rd_vld_r && rd_kind_r == ptq_pkg::RK_POP && rd_idx_r != '0) begin
      we    = 1'b1;
      waddr = rd_idx_dn[AW-1:0];
    end
  end

  ptq_ram #(
    .WIDTH (WORD_W),
    .DEPTH (QUEUE_DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (idx_r[AW-1:0]),
    .rdata (rdata)
  );

  always_comb begin
    case (cmd.idx_op)
      ptq_pkg::IDX_ZERO: idx_nxt = '0;
      ptq_pkg::IDX_ONE:  idx_nxt = CNT_W'(1);
      ptq_pkg::IDX_LAST: idx_nxt = len_m1;
      ptq_pkg::IDX_INC:  idx_nxt = idx_r + CNT_W'(1);
      ptq_pkg::IDX_DEC:  idx_nxt = idx_r - CNT_W'(1);
      default:           idx_nxt = idx_r;
    endcase
  end

  always_comb begin
    case (cmd.pos_op)
      ptq_pkg::POS_ZERO: pos_nxt = '0;
      ptq_pkg::POS_LEN:  pos_nxt = len_r;
      ptq_pkg::POS_SCAN: pos_nxt = prio_gt ? rd_idx_r : len_r;
      default:           pos_nxt = pos_r;
    endcase
  end

  assign ins_ok    = (op_r == ptq_pkg::OP_INSERT) && !full;
  assign pop_ok    = (op_r == ptq_pkg::OP_POP) && !len_zero;
  assign qry_ok    = (op_r == ptq_pkg::OP_QUERY) && found_r;
  assign res_valid = pop_ok || qry_ok;

  always_comb begin
    len_nxt = len_r;
    if (ins_ok) begin
      len_nxt = len_r + CNT_W'(1);
    end else if (pop_ok) begin
      len_nxt = len_m1;
    end
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      urgent_r    <= '0;
      len_r       <= '0;
      idx_r       <= '0;
      pos_r       <= '0;
      rd_vld_r    <= 1'b0;
      sv_r        <= 1'b0;
      found_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_valid) begin
        urgent_r <= cfg_data;
      end
      idx_r    <= idx_nxt;
      pos_r    <= pos_nxt;
      rd_vld_r <= cmd.rd;
      sv_r     <= rd_vld_r && (rd_kind_r == ptq_pkg::RK_QRY) && rd_hasdl;
      if (cmd.capture) begin
        found_r <= 1'b0;
      end else if (sv_r && (!found_r || slack_r < best_r)) begin
        found_r <= 1'b1;
      end
      if (cmd.finish && out_free) begin
        out_valid_r <= 1'b1;
        len_r       <= len_nxt;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      op_r    <= ptq_pkg::op_t'(in_operation);
      tag_r   <= TAG_BITS'(in_task_tag);
      prio_r  <= in_task_priority;
      hasdl_r <= |in_task_deadline;
      diff_r  <= in_task_deadline - in_current_time;
      now_r   <= in_current_time;
    end
    rd_kind_r <= cmd.rd_kind;
    rd_idx_r  <= idx_r;
    slack_r   <= rd_diff - now_r;
    stag_r    <= rd_tag;
    if (cmd.capture) begin
      rtag_r <= '0;
    end else if (rd_vld_r && rd_kind_r == ptq_pkg::RK_POP && rd_idx_r == '0) begin
      rtag_r <= rd_tag;
    end else if (sv_r && (!found_r || slack_r < best_r)) begin
      rtag_r <= stag_r;
      best_r <= slack_r;
    end
    if (cmd.finish && out_free) begin
      out_tag_r    <= res_valid ? ptq_pkg::TAG_IN_W'(rtag_r) : '0;
      out_rvalid_r <= res_valid;
      out_drop_r   <= (op_r == ptq_pkg::OP_INSERT) && full;
      out_cnt_r    <= len_nxt;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_result_tag     = out_tag_r;
  assign out_result_valid   = out_rvalid_r;
  assign out_insert_dropped = out_drop_r;
  assign out_entry_count    = out_cnt_r;

endmodule

// ----- sv/ptq_ctrl.sv -----
// ============================================================================
// ptq_ctrl - priority task queue sequencer
// Steps each operation through scan, shift and sweep phases and issues
// commands to the datapath.
// ============================================================================
module ptq_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_ready,
  input  ptq_pkg::sts_t sts,
  output ptq_pkg::cmd_t cmd
);

  ptq_pkg::state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ptq_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt   = state_r;
    in_ready    = 1'b0;
    cmd.capture = 1'b0;
    cmd.idx_op  = ptq_pkg::IDX_HOLD;
    cmd.rd      = 1'b0;
    cmd.rd_kind = ptq_pkg::RK_SCAN;
    cmd.pos_op  = ptq_pkg::POS_HOLD;
    cmd.wr_new  = 1'b0;
    cmd.finish  = 1'b0;
    case (state_r)
      ptq_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.capture = 1'b1;
          state_nxt   = ptq_pkg::ST_DECIDE;
        end
      end
      ptq_pkg::ST_DECIDE: begin
        case (sts.op)
          ptq_pkg::OP_INSERT: begin
            if (sts.full) begin
              state_nxt = ptq_pkg::ST_FINISH;
            end else if (sts.len_zero) begin
              cmd.pos_op = ptq_pkg::POS_ZERO;
              state_nxt  = ptq_pkg::ST_WR_NEW;
            end else if (sts.urgent_hit) begin
              cmd.pos_op = ptq_pkg::POS_ZERO;
              cmd.idx_op = ptq_pkg::IDX_LAST;
              state_nxt  = ptq_pkg::ST_SHIFT;
            end else if (sts.len_one) begin
              cmd.pos_op = ptq_pkg::POS_LEN;
              state_nxt  = ptq_pkg::ST_WR_NEW;
            end else begin
              cmd.idx_op = ptq_pkg::IDX_ONE;
              state_nxt  = ptq_pkg::ST_SCAN;
            end
          end
          ptq_pkg::OP_POP, ptq_pkg::OP_QUERY: begin
            if (sts.len_zero) begin
              state_nxt = ptq_pkg::ST_FINISH;
            end else begin
              cmd.idx_op = ptq_pkg::IDX_ZERO;
              state_nxt  = ptq_pkg::ST_SWEEP;
            end
          end
          default: begin
            state_nxt = ptq_pkg::ST_FINISH;
          end
        endcase
      end
      ptq_pkg::ST_SCAN: begin
        // stop at the first later entry of lower rank, or at the tail
        if (sts.scan_hit) begin
          cmd.pos_op = ptq_pkg::POS_SCAN;
          if (sts.scan_tail) begin
            state_nxt = ptq_pkg::ST_WR_NEW;
          end else begin
            cmd.idx_op = ptq_pkg::IDX_LAST;
            state_nxt  = ptq_pkg::ST_SHIFT;
          end
        end else begin
          cmd.rd      = 1'b1;
          cmd.rd_kind = ptq_pkg::RK_SCAN;
          cmd.idx_op  = ptq_pkg::IDX_INC;
        end
      end
      ptq_pkg::ST_SHIFT: begin
        cmd.rd      = 1'b1;
        cmd.rd_kind = ptq_pkg::RK_SHIFT;
        if (sts.idx_at_pos) begin
          state_nxt = ptq_pkg::ST_DRAIN1;
        end else begin
          cmd.idx_op = ptq_pkg::IDX_DEC;
        end
      end
      ptq_pkg::ST_SWEEP: begin
        cmd.rd      = 1'b1;
        cmd.rd_kind = (sts.op == ptq_pkg::OP_POP) ? ptq_pkg::RK_POP : ptq_pkg::RK_QRY;
        if (sts.idx_at_last) begin
          state_nxt = ptq_pkg::ST_DRAIN1;
        end else begin
          cmd.idx_op = ptq_pkg::IDX_INC;
        end
      end
      ptq_pkg::ST_DRAIN1: begin
        state_nxt = ptq_pkg::ST_DRAIN2;
      end
      ptq_pkg::ST_DRAIN2: begin
        state_nxt = (sts.op == ptq_pkg::OP_INSERT) ? ptq_pkg::ST_WR_NEW : ptq_pkg::ST_FINISH;
      end
      ptq_pkg::ST_WR_NEW: begin
        cmd.wr_new = 1'b1;
        state_nxt  = ptq_pkg::ST_FINISH;
      end
      ptq_pkg::ST_FINISH: begin
        cmd.finish = 1'b1;
        if (sts.out_free) begin
          state_nxt = ptq_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = ptq_pkg::ST_IDLE;
      end
    endcase
  end

endmodule

// ----- sv/priority_task_queue_edf_top.sv -----
// ============================================================================
// priority_task_queue_edf_top - bounded ordered task queue with EDF query
// Insert, pop-head and earliest-deadline query over a RAM-held task list.
// ============================================================================
// One operation is in flight at a time. Insert and pop keep the queue in
// order by moving entries through a single RAM with one read and one write
// port, one entry per cycle; the query sweeps the queue once. An insert that
// moves entries reaches them, wherever its slot lies, with a forward scan that
// stops at the slot and a move towards the tail that covers the rest. A new
// item is taken once the previous result has been written into the output
// register, even if that beat has not been taken yet; while that beat waits,
// the next result holds in the last step. The entry RAM is not cleared; only
// entries below the length are ever read. The urgent priority code is written
// through the cfg channel, which is always ready and should be used only while
// the queue is idle.
// ============================================================================
module priority_task_queue_edf_top #(
  parameter int QUEUE_DEPTH = 16,
  parameter int TAG_BITS    = 8
) (
  input  logic                               clk,
  input  logic                               rst_n,
  // configuration
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [ptq_pkg::PRIO_W-1:0]         cfg_data,
  // operation beats
  input  logic                               in_valid,
  output logic                               in_ready,
  input  logic [ptq_pkg::OP_W-1:0]           in_operation,
  input  logic [ptq_pkg::TAG_IN_W-1:0]       in_task_tag,
  input  logic [ptq_pkg::PRIO_W-1:0]         in_task_priority,
  input  logic [ptq_pkg::TIME_W-1:0]         in_task_deadline,
  input  logic [ptq_pkg::TIME_W-1:0]         in_current_time,
  // result beats
  output logic                               out_valid,
  input  logic                               out_ready,
  output logic [ptq_pkg::TAG_IN_W-1:0]       out_result_tag,
  output logic                               out_result_valid,
  output logic                               out_insert_dropped,
  output logic [$clog2(QUEUE_DEPTH+1)-1:0]   out_entry_count
);

  ptq_pkg::cmd_t cmd;
  ptq_pkg::sts_t sts;

  // the register write never has to wait
  assign cfg_ready = 1'b1;

  // sequencer: walks each operation through its phases
  ptq_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  // datapath: entry RAM, counters, slack compare, result register
  ptq_dp #(
    .QUEUE_DEPTH (QUEUE_DEPTH),
    .TAG_BITS    (TAG_BITS)
  ) u_dp (
    .clk                (clk),
    .rst_n              (rst_n),
    .cmd                (cmd),
    .sts                (sts),
    .cfg_valid          (cfg_valid),
    .cfg_data           (cfg_data),
    .in_operation       (in_operation),
    .in_task_tag        (in_task_tag),
    .in_task_priority   (in_task_priority),
    .in_task_deadline   (in_task_deadline),
    .in_current_time    (in_current_time),
    .out_ready          (out_ready),
    .out_valid          (out_valid),
    .out_result_tag     (out_result_tag),
    .out_result_valid   (out_result_valid),
    .out_insert_dropped (out_insert_dropped),
    .out_entry_count    (out_entry_count)
  );

endmodule

// ----- sv/ptq_checker.sv -----
// ============================================================================
// ptq_checker - port-level checks for the priority task queue
// Watches the top-level ports; attached by bind.
// ============================================================================
module ptq_checker #(
  parameter int QUEUE_DEPTH = 16
) (
  input logic                             clk,
  input logic                             rst_n,
  input logic                             in_valid,
  input logic                             in_ready,
  input logic                             out_valid,
  input logic                             out_ready,
  input logic [ptq_pkg::TAG_IN_W-1:0]     out_result_tag,
  input logic                             out_result_valid,
  input logic                             out_insert_dropped,
  input logic [$clog2(QUEUE_DEPTH+1)-1:0] out_entry_count
);

  // hold a stalled result beat
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_result_tag)
      && $stable(out_result_valid) && $stable(out_insert_dropped)
      && $stable(out_entry_count))
    else $error("result beat changed while stalled");

  // one operation at a time
  a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("second beat taken while busy");

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_entry_count <= QUEUE_DEPTH)
    else $error("entry count beyond depth");

  a_tag_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_result_valid |-> out_result_tag == '0)
    else $error("tag not zero without a result");

  a_drop_full: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_insert_dropped |-> out_entry_count == QUEUE_DEPTH && !out_result_valid)
    else $error("insert dropped while queue not full");

endmodule

bind priority_task_queue_edf_top ptq_checker #(
  .QUEUE_DEPTH (QUEUE_DEPTH)
) u_ptq_checker (
  .clk                (clk),
  .rst_n              (rst_n),
  .in_valid           (in_valid),
  .in_ready           (in_ready),
  .out_valid          (out_valid),
  .out_ready          (out_ready),
  .out_result_tag     (out_result_tag),
  .out_result_valid   (out_result_valid),
  .out_insert_dropped (out_insert_dropped),
  .out_entry_count    (out_entry_count)
);

// ----- verif/priority_task_queue_edf_top_tb.sv -----
`timescale 1ns / 1ps
// ============================================================================
// priority_task_queue_edf_top_tb - self-checking bench for the EDF task queue
// Sends insert, pop, query and no-op beats through the valid/ready channels,
// predicts each result beat with a behavioural copy of the ordered queue and
// compares it field by field. Runs under random idling on both sides, a long
// receiver hold-off and several urgent-priority settings.
// ============================================================================
module priority_task_queue_edf_top_tb;

  localparam int QUEUE_DEPTH     = 16;
  localparam int TAG_BITS        = 8;
  localparam int COUNT_W         = $clog2(QUEUE_DEPTH + 1);
  localparam int IDLE_PCT        = 36;
  // the worst insert grows with the queue length; leave a margin on top
  localparam int QUIET_CYCLES    = 2 * QUEUE_DEPTH + 16;
  localparam int HOLD_OFF_CYCLES = 400;
  // longest correct silence is the hold-off plus one slow operation
  localparam int WATCHDOG_LIMIT  = 4000;
  localparam int MAX_REPORTS     = 10;

  // one operation beat as offered on the input channel
  typedef struct {
    ptq_pkg::op_t                 op;
    logic [ptq_pkg::TAG_IN_W-1:0] tag;
    logic [ptq_pkg::PRIO_W-1:0]   prio;
    logic [ptq_pkg::TIME_W-1:0]   deadline;
    logic [ptq_pkg::TIME_W-1:0]   now_time;
  } task_beat_t;

  // one result beat, in port order
  typedef struct packed {
    logic [ptq_pkg::TAG_IN_W-1:0] tag;
    logic                         found;
    logic                         dropped;
    logic [COUNT_W-1:0]           count;
  } queue_result_t;

  // --------------------------------------------------------------------------
  // Clock, reset and DUT ports; every input is known from time zero
  // --------------------------------------------------------------------------
  logic clk   = 1'b0;
  logic rst_n = 1'b0;

  logic                         cfg_valid = 1'b0;
  logic                         cfg_ready;
  logic [ptq_pkg::PRIO_W-1:0]   cfg_data  = '0;

  logic                         in_valid         = 1'b0;
  logic                         in_ready;
  logic [ptq_pkg::OP_W-1:0]     in_operation     = '0;
  logic [ptq_pkg::TAG_IN_W-1:0] in_task_tag      = '0;
  logic [ptq_pkg::PRIO_W-1:0]   in_task_priority = '0;
  logic [ptq_pkg::TIME_W-1:0]   in_task_deadline = '0;
  logic [ptq_pkg::TIME_W-1:0]   in_current_time  = '0;

  logic                         out_valid;
  logic                         out_ready = 1'b0;
  logic [ptq_pkg::TAG_IN_W-1:0] out_result_tag;
  logic                         out_result_valid;
  logic                         out_insert_dropped;
  logic [COUNT_W-1:0]           out_entry_count;

  initial begin
    forever #2 clk = ~clk;
  end

  priority_task_queue_edf_top #(
    .QUEUE_DEPTH (QUEUE_DEPTH),
    .TAG_BITS    (TAG_BITS)
  ) DUT (
    .clk                (clk),
    .rst_n              (rst_n),
    .cfg_valid          (cfg_valid),
    .cfg_ready          (cfg_ready),
    .cfg_data           (cfg_data),
    .in_valid           (in_valid),
    .in_ready           (in_ready),
    .in_operation       (in_operation),
    .in_task_tag        (in_task_tag),
    .in_task_priority   (in_task_priority),
    .in_task_deadline   (in_task_deadline),
    .in_current_time    (in_current_time),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .out_result_tag     (out_result_tag),
    .out_result_valid   (out_result_valid),
    .out_insert_dropped (out_insert_dropped),
    .out_entry_count    (out_entry_count)
  );

  // --------------------------------------------------------------------------
  // Shadow queue: entries held in service order, index 0 is the head
  // --------------------------------------------------------------------------
  logic [ptq_pkg::TAG_IN_W-1:0] q_tag      [QUEUE_DEPTH];
  logic [ptq_pkg::PRIO_W-1:0]   q_prio     [QUEUE_DEPTH];
  logic [ptq_pkg::TIME_W-1:0]   q_deadline [QUEUE_DEPTH];
  logic [ptq_pkg::TIME_W-1:0]   q_issue    [QUEUE_DEPTH];
  int                           q_len;
  logic [ptq_pkg::PRIO_W-1:0]   urgent_code;

  queue_result_t                expected_results[$];
  int                           mismatch_count = 0;
  int                           idle_cycles    = 0;

  // stimulus shaping shared between the sender and the receiver
  bit                           steady_mode  = 1'b0;
  bit                           hold_off_req = 1'b0;
  int                           hold_left    = 0;
  logic [ptq_pkg::TIME_W-1:0]   time_base    = 32'hFFFF_F000;  // wraps early in the run

  function automatic void move_entry(int dst, int src);
    q_tag[dst]      = q_tag[src];
    q_prio[dst]     = q_prio[src];
    q_deadline[dst] = q_deadline[src];
    q_issue[dst]    = q_issue[src];
  endfunction

  // Apply one accepted beat to the shadow queue and return the result it owes.
  function automatic queue_result_t predict_queue_op(task_beat_t b);
    queue_result_t              r;
    int                         slot;
    int                         i;
    logic [ptq_pkg::TIME_W-1:0] slack;
    logic [ptq_pkg::TIME_W-1:0] best;
    r    = '0;
    best = '0;
    case (b.op)
      ptq_pkg::OP_INSERT: begin
        if (q_len >= QUEUE_DEPTH) begin
          r.dropped = 1'b1;
        end else begin
          // empty queue or urgent code: new head; otherwise behind the head
          // and behind every later entry of equal or better priority
          if (q_len == 0 || b.prio == urgent_code) begin
            slot = 0;
          end else begin
            slot = 1;
            while (slot < q_len && q_prio[slot] <= b.prio) slot++;
          end
          for (i = q_len; i > slot; i--) move_entry(i, i - 1);
          q_tag[slot]      = b.tag;
          q_prio[slot]     = b.prio;
          q_deadline[slot] = b.deadline;
          q_issue[slot]    = b.now_time;
          q_len++;
        end
      end
      ptq_pkg::OP_POP: begin
        if (q_len > 0) begin
          r.tag   = q_tag[0];
          r.found = 1'b1;
          for (i = 1; i < q_len; i++) move_entry(i - 1, i);
          q_len--;
        end
      end
      ptq_pkg::OP_QUERY: begin
        // first entry with a deadline and the smallest wrapped slack wins
        for (i = 0; i < q_len; i++) begin
          if (q_deadline[i] != '0) begin
            slack = q_deadline[i] - b.now_time - q_issue[i];
            if (!r.found || slack < best) begin
              r.found = 1'b1;
              best    = slack;
              r.tag   = q_tag[i];
            end
          end
        end
      end
      default: begin
      end
    endcase
    r.count = COUNT_W'(q_len);
    return r;
  endfunction

  task automatic flag_result(string why, queue_result_t want, queue_result_t got);
    mismatch_count++;
    if (mismatch_count <= MAX_REPORTS) begin
      $display("%0t ns: %s: expected tag=%02h found=%0b dropped=%0b count=%0d",
               $time, why, want.tag, want.found, want.dropped, want.count);
      $display("    got tag=%02h found=%0b dropped=%0b count=%0d",
               got.tag, got.found, got.dropped, got.count);
    end
  endtask

  // --------------------------------------------------------------------------
  // Monitor: all handshakes are sampled at the rising edge, so the pre-edge
  // values are seen regardless of process order. Check the result beat first
  // - it always belongs to an earlier operation - then predict the new one.
  // --------------------------------------------------------------------------
  always @(posedge clk) begin : queue_monitor
    queue_result_t got;
    queue_result_t want;
    task_beat_t    beat;
    if (!rst_n) begin
      q_len       = 0;
      urgent_code = '0;
      idle_cycles = 0;
    end else begin
      if (cfg_valid && cfg_ready) urgent_code = cfg_data;

      if (out_valid && out_ready) begin
        got = {out_result_tag, out_result_valid, out_insert_dropped, out_entry_count};
        if (expected_results.size() == 0) begin
          flag_result("result beat with nothing outstanding", '0, got);
        end else begin
          want = expected_results.pop_front();
          if (got !== want) flag_result("result mismatch", want, got);
        end
      end

      if (in_valid && in_ready) begin
        beat.op       = ptq_pkg::op_t'(in_operation);
        beat.tag      = in_task_tag;
        beat.prio     = in_task_priority;
        beat.deadline = in_task_deadline;
        beat.now_time = in_current_time;
        expected_results.push_back(predict_queue_op(beat));
      end

      // watchdog: count edges with no beat on any channel
      if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
        idle_cycles = 0;
      else
        idle_cycles++;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("priority_task_queue_edf_top_tb: FAIL");
        $finish;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Receiver: random stalls, none in steady stretches, and a long hold-off on
  // request that is counted here so the sender can keep pushing meanwhile.
  // --------------------------------------------------------------------------
  always @(posedge clk) begin : result_receiver
    if (!rst_n) begin
      out_ready <= 1'b0;
      hold_left = 0;
    end else begin
      if (hold_off_req && hold_left == 0) begin
        hold_left    = HOLD_OFF_CYCLES;
        hold_off_req = 1'b0;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else if (steady_mode) begin
        out_ready <= 1'b1;
      end else begin
        out_ready <= ($urandom_range(99) >= IDLE_PCT);
      end
    end
  end

  // --------------------------------------------------------------------------
  // Sender side
  // --------------------------------------------------------------------------

  // Offer one beat and hold it until taken; drop valid during random gaps.
  task automatic send_beat(task_beat_t b);
    while (!steady_mode && $urandom_range(99) < IDLE_PCT) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid         <= 1'b1;
    in_operation     <= b.op;
    in_task_tag      <= b.tag;
    in_task_priority <= b.prio;
    in_task_deadline <= b.deadline;
    in_current_time  <= b.now_time;
    do @(posedge clk); while (!in_ready);
  endtask

  // Lower valid, let every outstanding result drain, then allow the slowest
  // operation to settle so the block is truly idle.
  task automatic wait_for_quiet();
    in_valid <= 1'b0;
    do @(posedge clk); while (expected_results.size() != 0);
    repeat (QUIET_CYCLES) @(posedge clk);
  endtask

  task automatic write_urgent(logic [ptq_pkg::PRIO_W-1:0] code);
    wait_for_quiet();
    cfg_valid <= 1'b1;
    cfg_data  <= code;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
  endtask

  // Mostly meaningful traffic: ties, urgent hits, deadlines whose slack lands
  // near zero on both sides, and a time base that advances and wraps.
  function automatic task_beat_t random_beat(int insert_pct);
    task_beat_t b;
    int         pick;
    pick = $urandom_range(99);
    if (pick < insert_pct) begin
      b.op = ptq_pkg::OP_INSERT;
    end else begin
      pick = $urandom_range(99);
      b.op = (pick < 60) ? ptq_pkg::OP_POP : (pick < 95) ? ptq_pkg::OP_QUERY : ptq_pkg::OP_NOP;
    end
    b.tag = ptq_pkg::TAG_IN_W'($urandom);
    case ($urandom_range(3))
      0:       b.prio = urgent_code;
      1:       b.prio = ptq_pkg::PRIO_W'($urandom_range(7));
      2:       b.prio = ptq_pkg::PRIO_W'($urandom);
      default: b.prio = $urandom_range(1) ? 8'hFF : 8'h00;
    endcase
    time_base += $urandom_range(40);
    b.now_time = ($urandom_range(3) == 0) ? $urandom : time_base;
    case ($urandom_range(3))
      0:       b.deadline = '0;
      1:       b.deadline = $urandom;
      default: b.deadline = 2 * time_base + $urandom_range(2000);
    endcase
    return b;
  endfunction

  // Alternate filling and draining phases so the queue depth sweeps from
  // empty to full and back, with refused inserts in the filling phases.
  task automatic random_run(int beats);
    int k;
    for (k = 0; k < beats; k++)
      send_beat(random_beat(((k / 40) % 2 == 0) ? 75 : 30));
  endtask

  // --------------------------------------------------------------------------
  // Tests
  // --------------------------------------------------------------------------

  // Empty pop/query, no-op, field extremes, urgent head insert, wrapped slack,
  // query with no deadline entry, fill to full and a refused insert.
  task automatic test_directed_cases();
    int i;
    send_beat('{ptq_pkg::OP_POP,    8'h00, 8'h00, 32'h0000_0000, 32'h0000_0000});
    send_beat('{ptq_pkg::OP_QUERY,  8'hFF, 8'hFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF});
    send_beat('{ptq_pkg::OP_NOP,    8'hA5, 8'h5A, 32'h1234_5678, 32'h8765_4321});
    send_beat('{ptq_pkg::OP_INSERT, 8'hFF, 8'hFF, 32'h0000_0000, 32'hFFFF_FFFF});
    send_beat('{ptq_pkg::OP_QUERY,  8'h00, 8'h00, 32'h0000_0000, 32'h0000_0010});
    // priority 0 matches the reset urgent code: goes before the head
    send_beat('{ptq_pkg::OP_INSERT, 8'h00, 8'h00, 32'hFFFF_FFFF, 32'h0000_0000});
    send_beat('{ptq_pkg::OP_INSERT, 8'h5A, 8'h80, 32'h0000_0001, 32'hFFFF_FFFF});
    send_beat('{ptq_pkg::OP_QUERY,  8'h00, 8'h00, 32'h0000_0000, 32'h0000_0000});
    send_beat('{ptq_pkg::OP_QUERY,  8'h00, 8'h00, 32'h0000_0000, 32'hFFFF_FFFF});
    for (i = 0; i < QUEUE_DEPTH - 3; i++)
      send_beat('{ptq_pkg::OP_INSERT, 8'(8'h10 + i), 8'(8'h40 * (i % 4) + 8'h01),
                  (i % 3 == 0) ? 32'h0 : 32'(1000 - 37 * i), 32'(i * 5)});
    send_beat('{ptq_pkg::OP_INSERT, 8'hEE, 8'h02, 32'h0000_0100, 32'h0000_0100});
    send_beat('{ptq_pkg::OP_QUERY,  8'h00, 8'h00, 32'h0000_0000, 32'h0000_0050});
    send_beat('{ptq_pkg::OP_POP,    8'h00, 8'h00, 32'h0000_0000, 32'h0000_0000});
    send_beat('{ptq_pkg::OP_POP,    8'h00, 8'h00, 32'h0000_0000, 32'h0000_0000});
  endtask

  // Sweep the urgent code through its extremes and a few middle values.
  task automatic test_urgent_settings();
    logic [ptq_pkg::PRIO_W-1:0] codes[5] = '{8'hFF, 8'h00, 8'h01, 8'h80, 8'h00};
    int                         n;
    codes[4] = ptq_pkg::PRIO_W'($urandom);
    for (n = 0; n < 5; n++) begin
      write_urgent(codes[n]);
      random_run(180);
    end
  endtask

  // Hold the result side off for a long stretch while the sender keeps
  // offering beats back to back, so the block fills up and stalls its input.
  task automatic test_output_hold_off();
    steady_mode  = 1'b1;
    hold_off_req = 1'b1;
    random_run(120);
    steady_mode  = 1'b0;
  endtask

  // Bulk random traffic, opening with a stretch of no idling on either side.
  task automatic test_random_traffic();
    steady_mode = 1'b1;
    random_run(250);
    steady_mode = 1'b0;
    random_run(450);
  endtask

  initial begin
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_directed_cases();
    test_urgent_settings();
    test_output_hold_off();
    test_random_traffic();

    wait_for_quiet();
    if (mismatch_count == 0 && expected_results.size() == 0)
      $display("priority_task_queue_edf_top_tb: PASS");
    else
      $display("priority_task_queue_edf_top_tb: FAIL");
    $finish;
  end

endmodule
